>>> design/abkf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_pkg: shared types and helpers of the angle/bias Kalman filter
// Data widths, the divider status group and the round/saturate helpers.
// ----------------------------------------------------------------------------
package abkf_pkg;

  localparam int DATA_W = 32;            // Q16.16 angles, Q2.30 covariances
  localparam int MUL_W  = 33;            // shared multiplier operand width
  localparam int ACC_W  = 2 * MUL_W;     // product and accumulator width
  localparam int NUM_W  = 62;            // divider numerator |p| * 2^30
  localparam int QUO_W  = 33;            // divider quotient bits

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Round half up of v / 2^s, s >= 1.
  function automatic logic signed [ACC_W-1:0] rnd_shift(
      input logic signed [ACC_W-1:0] v, input int unsigned s);
    logic signed [ACC_W-1:0] t;
    t = v + (ACC_W'(1) << (s - 1));
    return t >>> s;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:DATA_W-1]) || !(|v[ACC_W-1:DATA_W-1])) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sx32(input logic signed [DATA_W-1:0] v);
    return ACC_W'(v);
  endfunction

endpackage
`default_nettype wire

>>> design/abkf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_mul: shared signed multiplier
// One 33 x 33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module abkf_mul
  import abkf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [MUL_W-1:0] op_a,
  input  wire logic signed [MUL_W-1:0] op_b,
  output logic signed [ACC_W-1:0]      prod
);

  logic signed [ACC_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

>>> design/abkf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_div: restoring divider for the Kalman gains
// Unsigned quotient of a 62-bit numerator by a 32-bit divisor, one bit a
// cycle; flags quotients that do not fit in 33 bits.
// ----------------------------------------------------------------------------
module abkf_div
  import abkf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DATA_W-1:0] den,
  output logic [QUO_W-1:0]       quo,
  output logic                   ovf,
  output div_stat_t              stat
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  nsh_r, quo_r;
  logic [DATA_W-1:0] den_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [DATA_W:0]   trial;
  logic              q_bit;

  always_comb begin
    trial = {rem_r, nsh_r[QUO_W-1]};
    q_bit = (trial >= {1'b0, den_r});
    rem_nxt = q_bit ? DATA_W'(trial - {1'b0, den_r}) : trial[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DATA_W'(num[NUM_W-1:QUO_W]);
      nsh_r <= num[QUO_W-1:0];
      den_r <= den;
      ovf_r <= (DATA_W'(num[NUM_W-1:QUO_W]) >= den);
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      nsh_r <= {nsh_r[QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[QUO_W-2:0], q_bit};
    end
  end

  assign quo       = quo_r;
  assign ovf       = ovf_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

>>> design/angle_bias_kalman_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter: two-state (angle, gyro bias) Kalman filter
// Per-axis predict/correct step run on one shared multiplier and a serial
// divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per sample; in_tuser carries the axis, in_tdata carries
//           the accelerometer angle (low word) and gyro rate (high word).
//   out_* : one beat per sample with the filtered angle, Q16.16 saturated.
//   cfg_* : APB register port; time_step at 0x0, angle_noise at 0x4,
//           bias_noise at 0x8, measurement_noise at 0xC. pready stays high.
// Schedule:
//   The block takes one beat at a time. The 13 products of a step each use
//   the shared multiplier in an issue state and then a use state (ST_MUL,
//   ST_USE); the two gains each take a run of the bit-serial divider, with
//   the ST_GAP state between them. When the innovation covariance is not
//   positive the divisions are skipped. in_tready is low for the whole step.
// Reset:
//   rst_n (synchronous) clears all per-axis state to zero, loads the default
//   registers and empties the output register.
// Back-pressure:
//   The result sits in the output register until taken; in_tready returns
//   high as soon as the step has written its result, so the next sample may
//   already be taken while that result waits.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter
  import abkf_pkg::*;
#(
  parameter int AXES = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] measured_angle, [63:32] gyro_rate
  input  wire logic        in_tuser,   // [0] axis
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] filtered_angle
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd2;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd3;

  // multiplier step codes
  localparam logic [3:0] STP_ANGLE   = 4'd0;   // dt * rate
  localparam logic [3:0] STP_DT_P11  = 4'd1;   // dt * p11
  localparam logic [3:0] STP_DT_T    = 4'd2;   // dt * rounded(dt * p11)
  localparam logic [3:0] STP_DT_P01  = 4'd3;
  localparam logic [3:0] STP_DT_P10  = 4'd4;
  localparam logic [3:0] STP_DT_QA   = 4'd5;   // dt * angle noise, closes p00
  localparam logic [3:0] STP_QB_DT   = 4'd6;   // bias noise * dt, closes p11
  localparam logic [3:0] STP_K0_Y    = 4'd7;
  localparam logic [3:0] STP_K1_Y    = 4'd8;
  localparam logic [3:0] STP_K0_P00  = 4'd9;
  localparam logic [3:0] STP_K0_P01  = 4'd10;
  localparam logic [3:0] STP_K1_P00  = 4'd11;
  localparam logic [3:0] STP_K1_P01  = 4'd12;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_USE  = 7'b0000100,
    ST_DIVS = 7'b0001000,
    ST_DIVW = 7'b0010000,
    ST_OUT  = 7'b0100000,
    ST_GAP  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] step_r;
  logic       div_sel_r;

  // configuration
  logic [23:0] time_step_r;
  logic [29:0] angle_noise_r, bias_noise_r, meas_noise_r;

  // per-axis state
  logic signed [DATA_W-1:0] angle_est_r [AXES];
  logic signed [DATA_W-1:0] bias_est_r  [AXES];
  logic signed [DATA_W-1:0] cov_aa_r    [AXES];
  logic signed [DATA_W-1:0] cov_ab_r    [AXES];
  logic signed [DATA_W-1:0] cov_ba_r    [AXES];
  logic signed [DATA_W-1:0] cov_bb_r    [AXES];

  // working registers
  logic [AW-1:0]            idx_r;
  logic signed [DATA_W-1:0] meas_r, gyro_r, ang_r, y_r, k0_r, k1_r;
  logic signed [DATA_W-1:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic signed [MUL_W-1:0]  t_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_tvalid_r;
  logic [DATA_W-1:0]        out_tdata_r;

  // shared units
  logic signed [MUL_W-1:0] op_a, op_b;
  logic signed [ACC_W-1:0] prod;
  logic [NUM_W-1:0]        div_num;
  logic [DATA_W-1:0]       div_den;
  logic [QUO_W-1:0]        div_quo;
  logic                    div_ovf;
  div_stat_t               div_stat;
  logic                    div_start;

  logic                     in_fire, cfg_wr, out_free;
  logic [AW-1:0]            in_idx;
  logic signed [DATA_W-1:0] rate, div_p, gain;
  logic [DATA_W-1:0]        div_mag;
  logic signed [DATA_W+1:0] innov_cov;
  logic signed [MUL_W-1:0]  dt_op;

  assign in_idx   = (AXES > 1) ? AW'(in_tuser) : '0;
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TIME_STEP:   cfg_prdata = {8'd0, time_step_r};
      REG_ANGLE_NOISE: cfg_prdata = {2'd0, angle_noise_r};
      REG_BIAS_NOISE:  cfg_prdata = {2'd0, bias_noise_r};
      REG_MEAS_NOISE:  cfg_prdata = {2'd0, meas_noise_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // gyro rate minus bias, then operand selection for the shared multiplier
  assign rate  = sat32(sx32(gyro_r) - sx32(bias_est_r[idx_r]));
  assign dt_op = MUL_W'(time_step_r);

  always_comb begin
    op_a = dt_op;
    op_b = MUL_W'(rate);
    case (step_r)
      STP_ANGLE:  begin op_a = dt_op; op_b = MUL_W'(rate); end
      STP_DT_P11: begin op_a = dt_op; op_b = MUL_W'(cov_bb_r[idx_r]); end
      STP_DT_T:   begin op_a = dt_op; op_b = t_r; end
      STP_DT_P01: begin op_a = dt_op; op_b = MUL_W'(cov_ab_r[idx_r]); end
      STP_DT_P10: begin op_a = dt_op; op_b = MUL_W'(cov_ba_r[idx_r]); end
      STP_DT_QA:  begin op_a = dt_op; op_b = MUL_W'(angle_noise_r); end
      STP_QB_DT:  begin op_a = MUL_W'(bias_noise_r); op_b = dt_op; end
      STP_K0_Y:   begin op_a = MUL_W'(k0_r); op_b = MUL_W'(y_r); end
      STP_K1_Y:   begin op_a = MUL_W'(k1_r); op_b = MUL_W'(y_r); end
      STP_K0_P00: begin op_a = MUL_W'(k0_r); op_b = MUL_W'(pp00_r); end
      STP_K0_P01: begin op_a = MUL_W'(k0_r); op_b = MUL_W'(pp01_r); end
      STP_K1_P00: begin op_a = MUL_W'(k1_r); op_b = MUL_W'(pp00_r); end
      STP_K1_P01: begin op_a = MUL_W'(k1_r); op_b = MUL_W'(pp01_r); end
      default:    begin op_a = dt_op; op_b = MUL_W'(rate); end
    endcase
  end

  abkf_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // gain division: |p| * 2^30 / s, sign of p applied afterwards
  assign innov_cov = (DATA_W+2)'(pp00_r) + (DATA_W+2)'(meas_noise_r);
  assign div_p     = div_sel_r ? pp10_r : pp00_r;
  assign div_mag   = div_p[DATA_W-1] ? (~div_p + DATA_W'(1)) : div_p;
  assign div_num   = {div_mag, 30'd0};
  assign div_den   = innov_cov[DATA_W-1:0];
  assign div_start = (state_r == ST_DIVS);

  abkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .ovf   (div_ovf),
    .stat  (div_stat)
  );

  always_comb begin
    if (div_p[DATA_W-1]) begin
      if (div_ovf || (div_quo > QUO_W'(33'h080000000))) begin
        gain = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        gain = DATA_W'(~div_quo + QUO_W'(1));
      end
    end else begin
      if (div_ovf || div_quo[QUO_W-1] || div_quo[DATA_W-1]) begin
        gain = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        gain = div_quo[DATA_W-1:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_USE;
      ST_USE: begin
        if (step_r == STP_QB_DT) begin
          // signed test: skip both divisions unless s is strictly positive
          state_nxt = (innov_cov > (DATA_W+2)'(0)) ? ST_DIVS : ST_MUL;
        end else if (step_r == STP_K1_P01) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIVS: state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_stat.done) state_nxt = div_sel_r ? ST_MUL : ST_GAP;
      end
      ST_GAP:  state_nxt = ST_DIVS;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control, configuration and per-axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      div_sel_r     <= 1'b0;
      out_tvalid_r  <= 1'b0;
      time_step_r   <= 24'd16777;
      angle_noise_r <= 30'd1073742;
      bias_noise_r  <= 30'd3221225;
      meas_noise_r  <= 30'd32212255;
      for (int i = 0; i < AXES; i++) begin
        angle_est_r[i] <= '0;
        bias_est_r[i]  <= '0;
        cov_aa_r[i]    <= '0;
        cov_ab_r[i]    <= '0;
        cov_ba_r[i]    <= '0;
        cov_bb_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_TIME_STEP:   time_step_r   <= cfg_pwdata[23:0];
          REG_ANGLE_NOISE: angle_noise_r <= cfg_pwdata[29:0];
          REG_BIAS_NOISE:  bias_noise_r  <= cfg_pwdata[29:0];
          REG_MEAS_NOISE:  meas_noise_r  <= cfg_pwdata[29:0];
          default: ;
        endcase
      end
      // load a new beat when the output register frees up, else drop a taken one
      if (state_r == ST_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          step_r    <= '0;
          div_sel_r <= 1'b0;
        end
        ST_USE: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            STP_K1_Y: bias_est_r[idx_r] <=
                sat32(sx32(bias_est_r[idx_r]) + rnd_shift(prod, 30));
            STP_K0_P00: cov_aa_r[idx_r] <= sat32(sx32(pp00_r) - rnd_shift(prod, 30));
            STP_K0_P01: cov_ab_r[idx_r] <= sat32(sx32(pp01_r) - rnd_shift(prod, 30));
            STP_K1_P00: cov_ba_r[idx_r] <= sat32(sx32(pp10_r) - rnd_shift(prod, 30));
            STP_K1_P01: cov_bb_r[idx_r] <= sat32(sx32(pp11_r) - rnd_shift(prod, 30));
            default: ;
          endcase
        end
        ST_DIVW: if (div_stat.done) div_sel_r <= 1'b1;
        ST_OUT: begin
          if (out_free) begin
            angle_est_r[idx_r] <= ang_r;
          end
        end
        default: ;
      endcase
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r  <= in_idx;
      meas_r <= in_tdata[31:0];
      gyro_r <= in_tdata[63:32];
    end
    if (state_r == ST_OUT && out_free) out_tdata_r <= ang_r;
    if (state_r == ST_DIVW && div_stat.done) begin
      if (div_sel_r) k1_r <= gain;
      else           k0_r <= gain;
    end
    if (state_r == ST_USE) begin
      case (step_r)
        STP_ANGLE:  ang_r <= sat32(sx32(angle_est_r[idx_r]) + rnd_shift(prod, 24));
        STP_DT_P11: t_r   <= MUL_W'(rnd_shift(prod, 24));
        STP_DT_T:   acc_r <= prod;
        STP_DT_P01: acc_r <= acc_r - prod;
        STP_DT_P10: acc_r <= acc_r - prod;
        STP_DT_QA: begin
          pp00_r <= sat32(sx32(cov_aa_r[idx_r]) + rnd_shift(acc_r + prod, 24));
          pp01_r <= sat32(sx32(cov_ab_r[idx_r]) - ACC_W'(t_r));
          pp10_r <= sat32(sx32(cov_ba_r[idx_r]) - ACC_W'(t_r));
        end
        STP_QB_DT: begin
          pp11_r <= sat32(sx32(cov_bb_r[idx_r]) + rnd_shift(prod, 24));
          // drop both gains; the divider overwrites them when s > 0
          k0_r   <= '0;
          k1_r   <= '0;
          y_r    <= sat32(sx32(meas_r) - sx32(ang_r));
        end
        STP_K0_Y:   ang_r <= sat32(sx32(ang_r) + rnd_shift(prod, 30));
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
      in_fire |=> !in_tready)
    else $error("input taken while a step is in progress");

  a_use_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == ST_USE |-> $past(state_r) == ST_MUL)
    else $error("product used without an issue cycle");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
      div_stat.done |-> state_r == ST_DIVW)
    else $error("divider finished outside its wait state");

  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
      div_stat.busy |-> state_r == ST_DIVW)
    else $error("divider running outside its wait state");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
      step_r <= STP_K1_P01 || state_r == ST_OUT || state_r == ST_IDLE)
    else $error("step counter out of range");
`endif

endmodule
`default_nettype wire
